// ===== hw/rtl/bdf_pkg.sv =====
// Shared types, constants and the microcode program of the biquad filter.
package bdf_pkg;

   localparam int SAMPLE_BITS_DEF = 24;
   localparam int COEF_BITS_DEF   = 32;
   localparam int STATE_BITS_DEF  = 40;

   localparam int CSR_IDX_BITS = 3;

   localparam int NUM_STEPS = 13;
   localparam int PC_BITS   = $clog2(NUM_STEPS);

   // Microcode addresses
   localparam logic [PC_BITS-1:0] STEP_IDLE     = PC_BITS'(0);
   localparam logic [PC_BITS-1:0] STEP_MUL_B0X  = PC_BITS'(1);
   localparam logic [PC_BITS-1:0] STEP_MUL_B1X  = PC_BITS'(2);
   localparam logic [PC_BITS-1:0] STEP_SUM_Y    = PC_BITS'(3);
   localparam logic [PC_BITS-1:0] STEP_WR_Y     = PC_BITS'(4);
   localparam logic [PC_BITS-1:0] STEP_MUL_A1LO = PC_BITS'(5);
   localparam logic [PC_BITS-1:0] STEP_MUL_A1HI = PC_BITS'(6);
   localparam logic [PC_BITS-1:0] STEP_MUL_B2X  = PC_BITS'(7);
   localparam logic [PC_BITS-1:0] STEP_SUB_A1Y  = PC_BITS'(8);
   localparam logic [PC_BITS-1:0] STEP_WR_S1    = PC_BITS'(9);
   localparam logic [PC_BITS-1:0] STEP_ADD_A2HI = PC_BITS'(10);
   localparam logic [PC_BITS-1:0] STEP_SUB_A2Y  = PC_BITS'(11);
   localparam logic [PC_BITS-1:0] STEP_FINISH   = PC_BITS'(12);

   typedef enum logic [CSR_IDX_BITS-1:0] {
      COEF_B0 = 3'd0,
      COEF_B1 = 3'd1,
      COEF_B2 = 3'd2,
      COEF_A1 = 3'd3,
      COEF_A2 = 3'd4
   } coef_sel_type;

   typedef enum logic [1:0] {
      COND_ALWAYS = 2'd0,
      COND_REQ    = 2'd1,
      COND_SLOT   = 2'd2
   } cond_type;

   typedef enum logic [1:0] {
      OPB_X   = 2'd0,
      OPB_YLO = 2'd1,
      OPB_YHI = 2'd2
   } opb_type;

   typedef enum logic [1:0] {
      PACC_HOLD   = 2'd0,
      PACC_LOAD   = 2'd1,
      PACC_ADD_HI = 2'd2
   } pacc_op_type;

   typedef enum logic [1:0] {
      BASE_SUM  = 2'd0,
      BASE_S1   = 2'd1,
      BASE_S2   = 2'd2,
      BASE_ZERO = 2'd3
   } base_type;

   typedef enum logic {
      RND_X = 1'b0,
      RND_Y = 1'b1
   } rnd_type;

   typedef enum logic [1:0] {
      WR_NONE = 2'd0,
      WR_Y    = 2'd1,
      WR_S1   = 2'd2,
      WR_S2   = 2'd3
   } wr_type;

   typedef struct packed {
      logic               take_req;
      cond_type           cond;
      logic               jump;
      logic [PC_BITS-1:0] target;
      logic               mul_en;
      coef_sel_type       coef_sel;
      opb_type            opb_sel;
      pacc_op_type        pacc_op;
      logic               sum_en;
      base_type           base_sel;
      logic               sum_sub;
      rnd_type            rnd_sel;
      wr_type             wr_sel;
      logic               out_load;
   } ucode_type;

   typedef struct packed {
      ucode_type cw;
      logic      accept;
      logic      out_fire;
   } ctrl_type;

   // Program ROM. The multiplier result is registered, so the product accumulator
   // picks up a product in the step after it is issued, and the sum in the step after that.
   function automatic ucode_type ucode_word(input logic [PC_BITS-1:0] addr);
      ucode_type w;
      w = '0;
      case (addr)
         STEP_IDLE: begin
            w.take_req = 1'b1;
            w.cond     = COND_REQ;
         end
         STEP_MUL_B0X: begin
            w.mul_en   = 1'b1;
            w.coef_sel = COEF_B0;
            w.opb_sel  = OPB_X;
         end
         STEP_MUL_B1X: begin
            w.pacc_op  = PACC_LOAD;
            w.mul_en   = 1'b1;
            w.coef_sel = COEF_B1;
            w.opb_sel  = OPB_X;
         end
         STEP_SUM_Y: begin
            w.sum_en   = 1'b1;
            w.base_sel = BASE_S1;
            w.rnd_sel  = RND_X;
            w.pacc_op  = PACC_LOAD;
         end
         STEP_WR_Y: begin
            w.wr_sel   = WR_Y;
            w.sum_en   = 1'b1;
            w.base_sel = BASE_S2;
            w.rnd_sel  = RND_X;
         end
         STEP_MUL_A1LO: begin
            w.mul_en   = 1'b1;
            w.coef_sel = COEF_A1;
            w.opb_sel  = OPB_YLO;
         end
         STEP_MUL_A1HI: begin
            w.pacc_op  = PACC_LOAD;
            w.mul_en   = 1'b1;
            w.coef_sel = COEF_A1;
            w.opb_sel  = OPB_YHI;
         end
         STEP_MUL_B2X: begin
            w.pacc_op  = PACC_ADD_HI;
            w.mul_en   = 1'b1;
            w.coef_sel = COEF_B2;
            w.opb_sel  = OPB_X;
         end
         STEP_SUB_A1Y: begin
            w.sum_en   = 1'b1;
            w.base_sel = BASE_SUM;
            w.sum_sub  = 1'b1;
            w.rnd_sel  = RND_Y;
            w.pacc_op  = PACC_LOAD;
            w.mul_en   = 1'b1;
            w.coef_sel = COEF_A2;
            w.opb_sel  = OPB_YLO;
         end
         STEP_WR_S1: begin
            w.wr_sel   = WR_S1;
            w.sum_en   = 1'b1;
            w.base_sel = BASE_ZERO;
            w.rnd_sel  = RND_X;
            w.pacc_op  = PACC_LOAD;
            w.mul_en   = 1'b1;
            w.coef_sel = COEF_A2;
            w.opb_sel  = OPB_YHI;
         end
         STEP_ADD_A2HI: begin
            w.pacc_op  = PACC_ADD_HI;
         end
         STEP_SUB_A2Y: begin
            w.sum_en   = 1'b1;
            w.base_sel = BASE_SUM;
            w.sum_sub  = 1'b1;
            w.rnd_sel  = RND_Y;
         end
         STEP_FINISH: begin
            w.wr_sel   = WR_S2;
            w.out_load = 1'b1;
            w.cond     = COND_SLOT;
            w.jump     = 1'b1;
            w.target   = STEP_IDLE;
         end
         default: begin
            w.jump   = 1'b1;
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== hw/rtl/bdf_sequencer.sv =====
// Step counter and microcode fetch with conditional jumps.
module bdf_sequencer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               slot_free,
   output logic               req_ready,
   output bdf_pkg::ctrl_type  ctrl
);

   logic [bdf_pkg::PC_BITS-1:0] pc_ff;
   logic [bdf_pkg::PC_BITS-1:0] pc_in;
   bdf_pkg::ucode_type          cw;
   logic                        cond_ok;

   assign cw = bdf_pkg::ucode_word(pc_ff);

   always_comb begin
      case (cw.cond)
         bdf_pkg::COND_ALWAYS: cond_ok = 1'b1;
         bdf_pkg::COND_REQ:    cond_ok = req_valid;
         bdf_pkg::COND_SLOT:   cond_ok = slot_free;
         default:              cond_ok = 1'b0;
      endcase
   end

   always_comb begin
      pc_in = pc_ff;
      if (cond_ok) begin
         pc_in = cw.jump ? cw.target : pc_ff + {{(bdf_pkg::PC_BITS-1){1'b0}}, 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= bdf_pkg::STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign req_ready     = cw.take_req;
   assign ctrl.cw       = cw;
   assign ctrl.accept   = cw.take_req & req_valid;
   assign ctrl.out_fire = cw.out_load & slot_free;

endmodule

// ===== hw/rtl/bdf_mul.sv =====
// Shared signed multiplier with a registered product.
module bdf_mul #(
   parameter int A_BITS = bdf_pkg::COEF_BITS_DEF,
   parameter int B_BITS = bdf_pkg::SAMPLE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             en,
   input  logic signed [A_BITS-1:0]         a,
   input  logic signed [B_BITS-1:0]         b,
   output logic signed [A_BITS+B_BITS-1:0]  product
);

   logic signed [A_BITS+B_BITS-1:0] product_ff;
   logic signed [A_BITS+B_BITS-1:0] product_in;

   assign product_in = a * b;

   always_ff @(posedge clock) begin
      if (en) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

// ===== hw/rtl/bdf_datapath.sv =====
// Coefficient registers, state, product accumulator, rounding, saturation and result register.
module bdf_datapath #(
   parameter int SAMPLE_BITS = bdf_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = bdf_pkg::COEF_BITS_DEF,
   parameter int STATE_BITS  = bdf_pkg::STATE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bdf_pkg::ctrl_type                   ctrl,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_in,
   input  logic                                req_restart,
   input  logic                                csr_we,
   input  logic [bdf_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [COEF_BITS-1:0]                csr_wdata,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic signed [SAMPLE_BITS-1:0]       rsp_sample_out,
   output logic                                rsp_clipped,
   output logic                                slot_free
);

   localparam int SAMPLE_FRAC = SAMPLE_BITS - 1;
   localparam int COEF_FRAC   = COEF_BITS - 4;
   localparam int STATE_FRAC  = STATE_BITS - 9;
   localparam int XSH         = COEF_FRAC + SAMPLE_FRAC - STATE_FRAC;
   localparam int YSH         = COEF_FRAC;
   localparam int OSH         = STATE_FRAC - SAMPLE_FRAC;
   localparam int HALF        = STATE_BITS / 2;
   localparam int MB0         = (SAMPLE_BITS > HALF + 1) ? SAMPLE_BITS : HALF + 1;
   localparam int MB          = (MB0 > STATE_BITS - HALF) ? MB0 : STATE_BITS - HALF;
   localparam int PROD_BITS   = COEF_BITS + MB;
   localparam int PW          = COEF_BITS + STATE_BITS;
   // sums reach b*x - a*y + s, below 2^(STATE_BITS+3)
   localparam int SW          = STATE_BITS + 4;
   localparam int RW          = STATE_BITS + 1 + ((OSH < 0) ? -OSH : 0);
   localparam int NUM_COEF    = int'(bdf_pkg::COEF_A2) + 1;

   localparam logic [COEF_BITS-1:0] B0_RESET = COEF_BITS'(1) << COEF_FRAC;
   localparam logic signed [STATE_BITS-1:0] STATE_MAX = {1'b0, {(STATE_BITS-1){1'b1}}};
   localparam logic signed [STATE_BITS-1:0] STATE_MIN = {1'b1, {(STATE_BITS-1){1'b0}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic [COEF_BITS-1:0]          coef_ff [NUM_COEF];
   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic signed [STATE_BITS-1:0]  y_ff, y_in;
   logic signed [STATE_BITS-1:0]  s1_ff, s1_in;
   logic signed [STATE_BITS-1:0]  s2_ff, s2_in;
   logic signed [PW-1:0]          pacc_ff, pacc_in;
   logic signed [SW-1:0]          sum_ff, sum_in;
   logic                          clip_ff, clip_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff;
   logic                          rsp_clip_ff;

   logic signed [COEF_BITS-1:0]   mul_a;
   logic signed [MB-1:0]          mul_b;
   logic signed [PROD_BITS-1:0]   product;

   logic signed [PW-1:0]          rx_full, ry_full, ry_sum;
   logic signed [SW-1:0]          rnd_val, base_val;
   logic [SW-STATE_BITS:0]        sum_top;
   logic                          state_sat_flag;
   logic signed [STATE_BITS-1:0]  state_sat;
   logic signed [RW-1:0]          ro_full;
   logic [RW-SAMPLE_BITS:0]       ro_top;
   logic                          out_sat_flag;
   logic signed [SAMPLE_BITS-1:0] out_sat;

   // Configuration; indexes past the last coefficient are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[bdf_pkg::COEF_B0] <= B0_RESET;
         coef_ff[bdf_pkg::COEF_B1] <= '0;
         coef_ff[bdf_pkg::COEF_B2] <= '0;
         coef_ff[bdf_pkg::COEF_A1] <= '0;
         coef_ff[bdf_pkg::COEF_A2] <= '0;
      end else if (csr_we && (csr_index <= bdf_pkg::COEF_A2)) begin
         coef_ff[csr_index] <= csr_wdata;
      end
   end

   // Multiplier operands: y goes in as an unsigned low half and a signed high half
   assign mul_a = $signed(coef_ff[ctrl.cw.coef_sel]);

   always_comb begin
      case (ctrl.cw.opb_sel)
         bdf_pkg::OPB_X:   mul_b = MB'(x_ff);
         bdf_pkg::OPB_YLO: mul_b = $signed({{(MB-HALF){1'b0}}, y_ff[HALF-1:0]});
         bdf_pkg::OPB_YHI: mul_b = MB'($signed(y_ff[STATE_BITS-1:HALF]));
         default:          mul_b = '0;
      endcase
   end

   bdf_mul #(
      .A_BITS (COEF_BITS),
      .B_BITS (MB)
   ) u_mul (
      .clock   (clock),
      .en      (ctrl.cw.mul_en),
      .a       (mul_a),
      .b       (mul_b),
      .product (product)
   );

   always_comb begin
      case (ctrl.cw.pacc_op)
         bdf_pkg::PACC_HOLD:   pacc_in = pacc_ff;
         bdf_pkg::PACC_LOAD:   pacc_in = PW'(product);
         bdf_pkg::PACC_ADD_HI: pacc_in = pacc_ff + (PW'(product) <<< HALF);
         default:              pacc_in = pacc_ff;
      endcase
   end

   // Round to nearest, ties away from zero: add half, less one when negative, then shift
   generate
      if (XSH > 0) begin : g_xround
         localparam logic signed [PW-1:0] XHALF = PW'(1) << (XSH - 1);
         logic signed [PW-1:0] rx_sum;
         assign rx_sum  = pacc_ff + XHALF - $signed({{(PW-1){1'b0}}, pacc_ff[PW-1]});
         assign rx_full = rx_sum >>> XSH;
      end else begin : g_xshift
         assign rx_full = pacc_ff <<< (-XSH);
      end
   endgenerate

   localparam logic signed [PW-1:0] YHALF = PW'(1) << (YSH - 1);
   assign ry_sum  = pacc_ff + YHALF - $signed({{(PW-1){1'b0}}, pacc_ff[PW-1]});
   assign ry_full = ry_sum >>> YSH;

   assign rnd_val = (ctrl.cw.rnd_sel == bdf_pkg::RND_X) ? $signed(rx_full[SW-1:0])
                                                        : $signed(ry_full[SW-1:0]);

   always_comb begin
      case (ctrl.cw.base_sel)
         bdf_pkg::BASE_SUM:  base_val = sum_ff;
         bdf_pkg::BASE_S1:   base_val = SW'(s1_ff);
         bdf_pkg::BASE_S2:   base_val = SW'(s2_ff);
         bdf_pkg::BASE_ZERO: base_val = '0;
         default:            base_val = '0;
      endcase
   end

   always_comb begin
      sum_in = sum_ff;
      if (ctrl.cw.sum_en) begin
         sum_in = ctrl.cw.sum_sub ? base_val - rnd_val : base_val + rnd_val;
      end
   end

   // Saturate the running sum to the state width
   assign sum_top        = sum_ff[SW-1:STATE_BITS-1];
   assign state_sat_flag = !((&sum_top) || !(|sum_top));
   assign state_sat      = state_sat_flag ? (sum_ff[SW-1] ? STATE_MIN : STATE_MAX)
                                          : sum_ff[STATE_BITS-1:0];

   // Output conversion of y to the sample format
   generate
      if (OSH > 0) begin : g_oround
         localparam logic signed [RW-1:0] OHALF = RW'(1) << (OSH - 1);
         logic signed [RW-1:0] ro_sum;
         assign ro_sum  = RW'(y_ff) + OHALF - $signed({{(RW-1){1'b0}}, y_ff[STATE_BITS-1]});
         assign ro_full = ro_sum >>> OSH;
      end else begin : g_oshift
         assign ro_full = RW'(y_ff) <<< (-OSH);
      end
   endgenerate

   assign ro_top       = ro_full[RW-1:SAMPLE_BITS-1];
   assign out_sat_flag = !((&ro_top) || !(|ro_top));
   assign out_sat      = out_sat_flag ? (ro_full[RW-1] ? SAMPLE_MIN : SAMPLE_MAX)
                                      : ro_full[SAMPLE_BITS-1:0];

   always_comb begin
      y_in    = y_ff;
      s1_in   = s1_ff;
      s2_in   = s2_ff;
      clip_in = clip_ff;
      if (ctrl.accept) begin
         clip_in = 1'b0;
         if (req_restart) begin
            s1_in = '0;
            s2_in = '0;
         end
      end
      case (ctrl.cw.wr_sel)
         bdf_pkg::WR_NONE: ;
         bdf_pkg::WR_Y:    y_in  = state_sat;
         bdf_pkg::WR_S1:   s1_in = state_sat;
         bdf_pkg::WR_S2:   s2_in = state_sat;
         default:          ;
      endcase
      if ((ctrl.cw.wr_sel != bdf_pkg::WR_NONE) && state_sat_flag) begin
         clip_in = 1'b1;
      end
   end

   // Result register frees the sequencer while the transaction waits
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.out_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff        <= '0;
         s2_ff        <= '0;
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         clip_ff      <= clip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         x_ff <= req_sample_in;
      end
      y_ff    <= y_in;
      pacc_ff <= pacc_in;
      sum_ff  <= sum_in;
      if (ctrl.out_fire) begin
         rsp_sample_ff <= out_sat;
         // s2 is saturated in this same step
         rsp_clip_ff   <= clip_ff | state_sat_flag | out_sat_flag;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_clipped    = rsp_clip_ff;

endmodule

// ===== hw/rtl/biquad_df2t_filter_top.sv =====
// Top level of the transposed direct form II biquad filter.
// One sample is accepted per pass, none while a pass runs: an idle step that takes the
// transaction, then a 12-step microcode program that issues seven products (b0*x, b1*x,
// b2*x and a1*y, a2*y, each of the latter in two halves) through one shared registered
// multiplier, accumulates them, and saturates y, s1 and s2. The result sits in an output
// register, so the next sample is taken while the previous result waits; the program holds
// on its last step only if that register is still full. Coefficients are signed Q4.28,
// written through the csr port; the user must write them only while the filter is idle,
// which the block does not enforce. Writes to indexes past a2 are ignored. req_restart
// clears both state words before its sample is filtered. rsp_clipped reports saturation
// of y, either state word or the output sample.
module biquad_df2t_filter_top #(
   parameter int SAMPLE_BITS = bdf_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = bdf_pkg::COEF_BITS_DEF,
   parameter int STATE_BITS  = bdf_pkg::STATE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_in,
   input  logic                                req_restart,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]       rsp_sample_out,
   output logic                                rsp_clipped,
   input  logic                                csr_we,
   input  logic [bdf_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [COEF_BITS-1:0]                csr_wdata
);

   bdf_pkg::ctrl_type ctrl;
   logic              slot_free;

   bdf_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .slot_free (slot_free),
      .req_ready (req_ready),
      .ctrl      (ctrl)
   );

   bdf_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS),
      .STATE_BITS  (STATE_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .req_sample_in  (req_sample_in),
      .req_restart    (req_restart),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_sample_out (rsp_sample_out),
      .rsp_clipped    (rsp_clipped),
      .slot_free      (slot_free)
   );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the transposed direct form II biquad filter.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SMP_W    = bdf_pkg::SAMPLE_BITS_DEF;
   localparam int CF_W     = bdf_pkg::COEF_BITS_DEF;
   localparam int ST_W     = bdf_pkg::STATE_BITS_DEF;
   localparam int IDX_W    = bdf_pkg::CSR_IDX_BITS;
   localparam int CF_FRAC  = CF_W - 4;
   localparam int SMP_FRAC = SMP_W - 1;
   localparam int ST_FRAC  = ST_W - 9;
   localparam int X_SHIFT  = CF_FRAC + SMP_FRAC - ST_FRAC;
   localparam int Y_SHIFT  = ST_FRAC - SMP_FRAC;
   localparam int MAX_GAP  = 13;
   localparam int SETTLE   = 20;
   localparam int ONE_Q28  = 1 << CF_FRAC;

   localparam logic [CF_W-1:0] COEF_MAX  = {1'b0, {(CF_W-1){1'b1}}};
   localparam logic [CF_W-1:0] COEF_MIN  = {1'b1, {(CF_W-1){1'b0}}};
   localparam logic [CF_W-1:0] COEF_UNIT = CF_W'(ONE_Q28);

   localparam logic signed [SMP_W-1:0] SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
   localparam logic signed [SMP_W-1:0] SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};

   typedef enum int {SET_STABLE, SET_WILD, SET_EXTREME, SET_MIXED} coef_set_kind_type;

   typedef struct packed {
      logic signed [SMP_W-1:0] sample_out;
      logic                    clipped;
   } filt_result_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic signed [SMP_W-1:0]        req_sample_in = '0;
   logic                           req_restart = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic signed [SMP_W-1:0]        rsp_sample_out;
   logic                           rsp_clipped;
   logic                           csr_we = 1'b0;
   logic [IDX_W-1:0]               csr_index = '0;
   logic [CF_W-1:0]                csr_wdata = '0;

   // filter model: coefficients and the two delay words
   longint          coef_val [bdf_pkg::COEF_B0:bdf_pkg::COEF_A2];
   longint          delay_s1;
   longint          delay_s2;
   filt_result_type expected_q [$];

   int errors     = 0;
   int n_sent     = 0;
   int n_checked  = 0;
   int n_clipped  = 0;
   int n_sets     = 0;
   int stall_left = 0;
   bit send_burst = 1'b0;
   bit recv_burst = 1'b0;

   biquad_df2t_filter_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .req_restart    (req_restart),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .rsp_clipped    (rsp_clipped),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #5 clock = ~clock;

   // round(a*b / 2^sh) with ties away from zero, magnitude capped at 2^61
   function automatic longint scale_product(input longint a, input longint b, input int sh,
                                            inout bit clip);
      logic [127:0] ua;
      logic [127:0] ub;
      logic [127:0] prod;
      bit           neg;
      neg  = (a < 0) != (b < 0);
      ua   = (a < 0) ? 128'(-a) : 128'(a);
      ub   = (b < 0) ? 128'(-b) : 128'(b);
      prod = ua * ub;
      prod = (prod + (128'(1) << (sh - 1))) >> sh;
      if (prod > (128'(1) << 61)) begin
         prod = 128'(1) << 61;
         clip = 1'b1;
      end
      return neg ? -longint'(prod) : longint'(prod);
   endfunction

   function automatic longint clamp(input longint v, input int bits, inout bit clip);
      longint hi;
      longint lo;
      hi = (longint'(1) << (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         clip = 1'b1;
         return hi;
      end
      if (v < lo) begin
         clip = 1'b1;
         return lo;
      end
      return v;
   endfunction

   function automatic filt_result_type filter_sample(input logic signed [SMP_W-1:0] x_in,
                                                     input logic rs);
      bit              clip;
      longint          x;
      longint          y;
      longint          s1_next;
      longint          s2_next;
      longint          y_out;
      filt_result_type r;
      clip = 1'b0;
      x    = x_in;
      if (rs) begin
         delay_s1 = 0;
         delay_s2 = 0;
      end
      y = clamp(scale_product(coef_val[bdf_pkg::COEF_B0], x, X_SHIFT, clip) + delay_s1,
                ST_W, clip);
      s1_next = scale_product(coef_val[bdf_pkg::COEF_B1], x, X_SHIFT, clip)
              - scale_product(coef_val[bdf_pkg::COEF_A1], y, CF_FRAC, clip) + delay_s2;
      s2_next = scale_product(coef_val[bdf_pkg::COEF_B2], x, X_SHIFT, clip)
              - scale_product(coef_val[bdf_pkg::COEF_A2], y, CF_FRAC, clip);
      delay_s1 = clamp(s1_next, ST_W, clip);
      delay_s2 = clamp(s2_next, ST_W, clip);
      y_out = clamp(scale_product(y, 1, Y_SHIFT, clip), SMP_W, clip);
      r.sample_out = y_out[SMP_W-1:0];
      r.clipped    = clip;
      return r;
   endfunction

   // leaves csr_we high; the caller drops it after its last write
   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CF_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx <= bdf_pkg::COEF_A2)
         coef_val[bdf_pkg::coef_sel_type'(idx)] = $signed(val);
   endtask

   task automatic load_coefs(input logic [CF_W-1:0] b0, input logic [CF_W-1:0] b1,
                             input logic [CF_W-1:0] b2, input logic [CF_W-1:0] a1,
                             input logic [CF_W-1:0] a2);
      write_reg(bdf_pkg::COEF_B0, b0);
      write_reg(bdf_pkg::COEF_B1, b1);
      write_reg(bdf_pkg::COEF_B2, b2);
      write_reg(bdf_pkg::COEF_A1, a1);
      write_reg(bdf_pkg::COEF_A2, a2);
      csr_we <= 1'b0;
      n_sets++;
   endtask

   task automatic send_sample(input logic signed [SMP_W-1:0] x, input logic rs);
      int gap;
      if ($urandom_range(0, 49) == 0)
         send_burst = !send_burst;
      gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= x;
      req_restart   <= rs;
      do @(posedge clock); while (!req_ready);
      expected_q.push_back(filter_sample(x, rs));
      n_sent++;
   endtask

   // stop sending and let every outstanding transaction come back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_q.size() != 0);
   endtask

   task automatic test_unity_gain();
      send_sample(SMP_MAX, 1'b1);
      send_sample(SMP_MIN, 1'b0);
      send_sample('0, 1'b0);
      send_sample(SMP_W'(1), 1'b0);
      send_sample(-SMP_W'(1), 1'b1);
      send_sample(SMP_W'(24'h5A5A5A), 1'b0);
      drain();
   endtask

   // tiny coefficients so products and the output conversion land on halves
   task automatic test_rounding_ties();
      load_coefs(CF_W'(1 << X_SHIFT), CF_W'(1 << (X_SHIFT - 1)), -CF_W'(1 << (X_SHIFT - 1)),
                 '0, '0);
      send_sample(SMP_W'(128), 1'b1);
      send_sample(-SMP_W'(128), 1'b0);
      send_sample(SMP_W'(384), 1'b0);
      send_sample(-SMP_W'(384), 1'b0);
      send_sample(SMP_W'(1), 1'b0);
      send_sample(-SMP_W'(1), 1'b0);
      drain();
   endtask

   task automatic test_saturation();
      int i;
      load_coefs(COEF_MAX, '0, '0, '0, '0);
      send_sample(SMP_MAX, 1'b1);
      send_sample(SMP_MIN, 1'b0);
      drain();
      load_coefs(COEF_MIN, '0, '0, '0, '0);
      send_sample(SMP_MIN, 1'b0);
      send_sample(SMP_MAX, 1'b0);
      drain();
      // strong positive feedback: state words and the wide y run into their limits
      load_coefs(COEF_UNIT, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN);
      send_sample(SMP_MAX, 1'b1);
      for (i = 0; i < 4; i++)
         send_sample(SMP_MAX, 1'b0);
      send_sample(SMP_MIN, 1'b0);
      drain();
   endtask

   task automatic test_ignored_index();
      int k;
      for (k = 1; k <= (1 << IDX_W) - 1 - bdf_pkg::COEF_A2; k++)
         write_reg(IDX_W'(bdf_pkg::COEF_A2) + IDX_W'(k), CF_W'($urandom()));
      csr_we <= 1'b0;
      send_sample(SMP_W'(1000), 1'b1);
      send_sample(SMP_MAX, 1'b0);
      drain();
   endtask

   function automatic logic [CF_W-1:0] pick_coef(input coef_set_kind_type kind,
                                                 input bit fb_a1, input bit fb_a2,
                                                 input int a2_val);
      int lim;
      coef_set_kind_type k;
      k = kind;
      if (k == SET_MIXED)
         k = coef_set_kind_type'($urandom_range(SET_STABLE, SET_EXTREME));
      case (k)
         SET_WILD: return CF_W'($urandom());
         SET_EXTREME: begin
            case ($urandom_range(0, 4))
               0: return COEF_MAX;
               1: return COEF_MIN;
               2: return '0;
               3: return COEF_UNIT;
               default: return -COEF_UNIT;
            endcase
         end
         default: begin
            // keep the poles inside the stability triangle
            if (fb_a2)
               lim = (ONE_Q28 / 10) * 9;
            else if (fb_a1)
               lim = ((ONE_Q28 + a2_val) / 10) * 9;
            else
               lim = ONE_Q28;
            return CF_W'(int'($urandom_range(0, 2 * lim)) - lim);
         end
      endcase
   endfunction

   function automatic logic signed [SMP_W-1:0] pick_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5)
         return $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
      if (r < 25)
         return SMP_W'(int'($urandom_range(0, 8192)) - 4096);
      return SMP_W'($urandom());
   endfunction

   task automatic run_phase(input coef_set_kind_type kind, input int count);
      logic [CF_W-1:0] a2;
      int              i;
      a2 = pick_coef(kind, 1'b0, 1'b1, 0);
      load_coefs(pick_coef(kind, 1'b0, 1'b0, 0), pick_coef(kind, 1'b0, 1'b0, 0),
                 pick_coef(kind, 1'b0, 1'b0, 0),
                 pick_coef(kind, 1'b1, 1'b0, $signed(a2)), a2);
      for (i = 0; i < count; i++)
         send_sample(pick_sample(), $urandom_range(0, 24) == 0);
      drain();
   endtask

   task automatic test_random_filters();
      int p;
      for (p = 0; p < 4; p++)
         run_phase(SET_STABLE, 140);
      for (p = 0; p < 3; p++)
         run_phase(SET_MIXED, 110);
      for (p = 0; p < 2; p++)
         run_phase(SET_WILD, 100);
      // both ends of the coefficient range
      load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
      for (p = 0; p < 60; p++)
         send_sample(pick_sample(), $urandom_range(0, 9) == 0);
      drain();
      load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
      for (p = 0; p < 60; p++)
         send_sample(pick_sample(), $urandom_range(0, 9) == 0);
      drain();
   endtask

   // result side: random stalls and the field compare
   always @(posedge clock) begin
      filt_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            n_checked++;
            if (rsp_clipped)
               n_clipped++;
            if (expected_q.size() == 0) begin
               $error("unexpected transaction: sample_out %0d clipped %0b",
                      rsp_sample_out, rsp_clipped);
               errors++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_sample_out !== want.sample_out) begin
                  $error("sample_out: expected %0d, got %0d", want.sample_out, rsp_sample_out);
                  errors++;
               end
               if (rsp_clipped !== want.clipped) begin
                  $error("clipped: expected %0b, got %0b", want.clipped, rsp_clipped);
                  errors++;
               end
            end
            if ($urandom_range(0, 49) == 0)
               recv_burst = !recv_burst;
            stall_left = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      coef_val[bdf_pkg::COEF_B0] = ONE_Q28;
      coef_val[bdf_pkg::COEF_B1] = 0;
      coef_val[bdf_pkg::COEF_B2] = 0;
      coef_val[bdf_pkg::COEF_A1] = 0;
      coef_val[bdf_pkg::COEF_A2] = 0;
      delay_s1 = 0;
      delay_s2 = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_unity_gain();
      test_rounding_ties();
      test_saturation();
      test_ignored_index();
      test_random_filters();
      drain();
      repeat (SETTLE) @(posedge clock);
      $display("Filtered %0d samples (%0d checked) across %0d coefficient sets,",
               n_sent, n_checked, n_sets);
      $display("with restarts, random stalls on both sides; %0d outputs flagged clipping.",
               n_clipped);
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
